// ----- rtl/core/ers_pkg.sv -----
// shared types and constants for the elevator request scheduler
package ers_pkg;

    localparam int FLOOR_W = 7;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    localparam logic [FLOOR_W-1:0] FLOOR_COUNT_RESET = 7'd64;
    localparam logic [0:0]         REG_FLOOR_COUNT   = 1'b0;

    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef enum logic [1:0] {
        MOT_IDLE = 2'd0,
        MOT_UP   = 2'd1,
        MOT_DOWN = 2'd2
    } motion_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DUP      = 2'd1,
        ST_INVALID  = 2'd2,
        ST_AT_FLOOR = 2'd3
    } status_t;

    typedef struct packed {
        logic [FLOOR_W-1:0] lo_up_above;
        logic [FLOOR_W-1:0] hi_dn_below;
        logic [FLOOR_W-1:0] lo_up;
        logic [FLOOR_W-1:0] hi_up;
        logic [FLOOR_W-1:0] hi_dn;
    } scan_result_t;

endpackage

// ----- rtl/core/ers_if.sv -----
// request and result channel interfaces
interface ers_request_if;
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic [ers_pkg::FLOOR_W-1:0] request_floor;
    logic                        going_up;

    modport source (output valid, output mode, output request_floor, output going_up,
                    input ready);
    modport sink (input valid, input mode, input request_floor, input going_up,
                  output ready);
endinterface

interface ers_result_if;
    logic                        valid;
    logic                        ready;
    logic [ers_pkg::FLOOR_W-1:0] car_position;
    logic [1:0]                  motion;
    logic [ers_pkg::FLOOR_W-1:0] target_floor;
    logic                        served_up;
    logic                        served_down;
    logic [1:0]                  request_status;
    logic                        pending_any;

    modport source (output valid, output car_position, output motion, output target_floor,
                    output served_up, output served_down, output request_status,
                    output pending_any, input ready);
    modport sink (input valid, input car_position, input motion, input target_floor,
                  input served_up, input served_down, input request_status,
                  input pending_any, output ready);
endinterface

// ----- rtl/core/ers_apb_regs.sv -----
// apb configuration register holding the floor count
module ers_apb_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ers_pkg::ADDR_W-1:0]  paddr,
    input  logic [ers_pkg::DATA_W-1:0]  pwdata,
    output logic [ers_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output logic [ers_pkg::FLOOR_W-1:0] floor_count
);

    logic [ers_pkg::FLOOR_W-1:0] floor_count_reg;
    logic [ers_pkg::FLOOR_W-1:0] floor_count_next;
    logic                        hit;

    assign pready = 1'b1;
    assign hit    = (paddr[2] == ers_pkg::REG_FLOOR_COUNT);

    always_comb
    begin
        floor_count_next = floor_count_reg;
        if (psel && penable && pwrite && hit)
        begin
            floor_count_next = pwdata[ers_pkg::FLOOR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_count_reg <= ers_pkg::FLOOR_COUNT_RESET;
        end
        else
        begin
            floor_count_reg <= floor_count_next;
        end
    end

    assign prdata = hit ? {{(ers_pkg::DATA_W-ers_pkg::FLOOR_W){1'b0}}, floor_count_reg}
                        : '0;
    assign floor_count = floor_count_reg;

endmodule

// ----- rtl/core/ers_floor_scan.sv -----
// floor-by-floor sweep over both pending maps collecting target candidates
module ers_floor_scan #(
    parameter int FLOOR_CAPACITY = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [FLOOR_CAPACITY-1:0]   up_map,
    input  logic [FLOOR_CAPACITY-1:0]   down_map,
    input  logic [ers_pkg::FLOOR_W-1:0] car_floor,
    output logic                        done,
    output ers_pkg::scan_result_t       result
);

    localparam int IDX_W = $clog2(FLOOR_CAPACITY);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FLOOR_CAPACITY - 1);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } scan_state_t;

    scan_state_t                 state_reg, state_next;
    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic                        done_reg, done_next;
    ers_pkg::scan_result_t       res_reg, res_next;
    logic [ers_pkg::FLOOR_W-1:0] fl;
    logic                        up_bit;
    logic                        dn_bit;

    assign fl     = ers_pkg::FLOOR_W'(idx_reg) + 7'd1;
    assign up_bit = up_map[idx_reg];
    assign dn_bit = down_map[idx_reg];

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    idx_next   = '0;
                    res_next   = '0;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (up_bit && (fl > car_floor) && (res_reg.lo_up_above == '0))
                begin
                    res_next.lo_up_above = fl;
                end
                if (dn_bit && (fl < car_floor))
                begin
                    res_next.hi_dn_below = fl;
                end
                if (up_bit && (res_reg.lo_up == '0))
                begin
                    res_next.lo_up = fl;
                end
                if (up_bit)
                begin
                    res_next.hi_up = fl;
                end
                if (dn_bit)
                begin
                    res_next.hi_dn = fl;
                end
                if (idx_reg == LAST_IDX)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
            res_reg   <= res_next;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ----- rtl/core/elevator_request_scheduler.sv -----
// top level of the elevator request scheduler
// req channel: mode 0 adds a hall request (request_floor, going_up),
// mode 1 is a step tick; every request gives exactly one result on res.
// an add request is checked for invalid floor, current floor and duplicate,
// then recorded only if it passes; res.valid is set in S_ADD once the
// output slot is free. a tick sweeps the up and down pending maps one floor
// per cycle through a shared scan unit and picks the target; if there is
// one, it moves the car one floor toward it and clears both pending bits
// at the new floor; res.valid is set in S_APPLY once the scan is done and
// the output slot is free. req.ready is high only while no request is in
// progress, so a request is taken only after the last one's result is set.
// a finished result sits in an output register; a new request can be taken
// while it waits, but the next result holds until res.ready frees the slot.
// reset empties both maps, puts the car at floor one, idle, and sets the
// floor count register (apb, address 0) to 64.
module elevator_request_scheduler #(
    parameter int FLOOR_CAPACITY = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ers_pkg::ADDR_W-1:0]  paddr,
    input  logic [ers_pkg::DATA_W-1:0]  pwdata,
    output logic [ers_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    ers_request_if.sink                 req,
    ers_result_if.source                res
);

    localparam int FW    = ers_pkg::FLOOR_W;
    localparam int IDX_W = $clog2(FLOOR_CAPACITY);
    localparam logic [FW-1:0] CAP_F = FW'(FLOOR_CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD,
        S_SCAN,
        S_APPLY
    } state_t;

    state_t                  state_reg, state_next;
    logic [FLOOR_CAPACITY-1:0] up_reg, up_next;
    logic [FLOOR_CAPACITY-1:0] dn_reg, dn_next;
    logic [FW-1:0]           car_reg, car_next;
    ers_pkg::motion_t        motion_reg, motion_next;
    logic [FW-1:0]           floor_reg, floor_next;
    logic                    going_up_reg, going_up_next;
    logic [FW-1:0]           target_reg, target_next;
    logic                    scan_start_reg, scan_start_next;

    logic                    res_valid_reg, res_valid_next;
    logic [FW-1:0]           res_car_reg, res_car_next;
    ers_pkg::motion_t        res_motion_reg, res_motion_next;
    logic [FW-1:0]           res_target_reg, res_target_next;
    logic                    res_sup_reg, res_sup_next;
    logic                    res_sdn_reg, res_sdn_next;
    ers_pkg::status_t        res_status_reg, res_status_next;
    logic                    res_pend_reg, res_pend_next;

    logic [FW-1:0]           floor_count;
    logic [FW-1:0]           limit;
    logic                    scan_done;
    ers_pkg::scan_result_t   scan_res;
    logic                    slot_free;
    logic [FW-1:0]           req_m1;
    logic [IDX_W-1:0]        req_idx;
    ers_pkg::status_t        add_status;
    logic [FW-1:0]           pick;
    logic                    up_any;
    logic                    dn_any;
    logic [FW-1:0]           dist_up;
    logic [FW-1:0]           dist_dn;
    logic [FW-1:0]           idle_pick;
    logic [FW-1:0]           car_moved;
    logic [FW-1:0]           car_m1;
    logic [IDX_W-1:0]        car_idx;

    ers_apb_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .floor_count (floor_count)
    );

    ers_floor_scan #(
        .FLOOR_CAPACITY (FLOOR_CAPACITY)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (scan_start_reg),
        .up_map    (up_reg),
        .down_map  (dn_reg),
        .car_floor (car_reg),
        .done      (scan_done),
        .result    (scan_res)
    );

    assign limit     = (floor_count > CAP_F) ? CAP_F : floor_count;
    assign slot_free = !res_valid_reg || res.ready;
    assign req_m1    = floor_reg - 7'd1;
    assign req_idx   = req_m1[IDX_W-1:0];

    // add request checks in priority order
    always_comb
    begin
        if ((floor_reg == '0) || (floor_reg > limit))
        begin
            add_status = ers_pkg::ST_INVALID;
        end
        else if (floor_reg == car_reg)
        begin
            add_status = ers_pkg::ST_AT_FLOOR;
        end
        else if (going_up_reg ? up_reg[req_idx] : dn_reg[req_idx])
        begin
            add_status = ers_pkg::ST_DUP;
        end
        else
        begin
            add_status = ers_pkg::ST_OK;
        end
    end

    // target choice from the sweep candidates
    assign up_any  = (scan_res.lo_up != '0);
    assign dn_any  = (scan_res.hi_dn != '0);
    assign dist_up = (scan_res.lo_up > car_reg) ? scan_res.lo_up - car_reg
                                                : car_reg - scan_res.lo_up;
    assign dist_dn = (scan_res.hi_dn > car_reg) ? scan_res.hi_dn - car_reg
                                                : car_reg - scan_res.hi_dn;

    always_comb
    begin
        if (up_any && dn_any)
        begin
            idle_pick = (dist_up <= dist_dn) ? scan_res.lo_up : scan_res.hi_dn;
        end
        else if (up_any)
        begin
            idle_pick = scan_res.lo_up;
        end
        else
        begin
            idle_pick = scan_res.hi_dn;
        end

        if (!up_any && !dn_any)
        begin
            pick = '0;
        end
        else if ((motion_reg == ers_pkg::MOT_UP) && (scan_res.lo_up_above != '0))
        begin
            pick = scan_res.lo_up_above;
        end
        else if ((motion_reg == ers_pkg::MOT_UP) && dn_any)
        begin
            pick = scan_res.hi_dn;
        end
        else if ((motion_reg == ers_pkg::MOT_DOWN) && (scan_res.hi_dn_below != '0))
        begin
            pick = scan_res.hi_dn_below;
        end
        else if ((motion_reg == ers_pkg::MOT_DOWN) && up_any)
        begin
            pick = scan_res.hi_up;
        end
        else
        begin
            pick = idle_pick;
        end
    end

    always_comb
    begin
        if (target_reg > car_reg)
        begin
            car_moved = car_reg + 7'd1;
        end
        else if ((target_reg < car_reg) && (target_reg != '0))
        begin
            car_moved = car_reg - 7'd1;
        end
        else
        begin
            car_moved = car_reg;
        end
    end

    assign car_m1  = car_moved - 7'd1;
    assign car_idx = car_m1[IDX_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        up_next         = up_reg;
        dn_next         = dn_reg;
        car_next        = car_reg;
        motion_next     = motion_reg;
        floor_next      = floor_reg;
        going_up_next   = going_up_reg;
        target_next     = target_reg;
        scan_start_next = 1'b0;
        res_valid_next  = res_valid_reg && !res.ready;
        res_car_next    = res_car_reg;
        res_motion_next = res_motion_reg;
        res_target_next = res_target_reg;
        res_sup_next    = res_sup_reg;
        res_sdn_next    = res_sdn_reg;
        res_status_next = res_status_reg;
        res_pend_next   = res_pend_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    floor_next    = req.request_floor;
                    going_up_next = req.going_up;
                    if (req.mode == ers_pkg::MODE_TICK)
                    begin
                        scan_start_next = 1'b1;
                        state_next      = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_ADD;
                    end
                end
            end
            S_ADD:
            begin
                if (slot_free)
                begin
                    if (add_status == ers_pkg::ST_OK)
                    begin
                        if (going_up_reg)
                        begin
                            up_next[req_idx] = 1'b1;
                        end
                        else
                        begin
                            dn_next[req_idx] = 1'b1;
                        end
                    end
                    res_valid_next  = 1'b1;
                    res_car_next    = car_reg;
                    res_motion_next = motion_reg;
                    res_target_next = '0;
                    res_sup_next    = 1'b0;
                    res_sdn_next    = 1'b0;
                    res_status_next = add_status;
                    res_pend_next   = (|up_next) || (|dn_next);
                    state_next      = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    target_next = pick;
                    state_next  = S_APPLY;
                end
            end
            S_APPLY:
            begin
                if (slot_free)
                begin
                    res_sup_next = 1'b0;
                    res_sdn_next = 1'b0;
                    if (target_reg == '0)
                    begin
                        motion_next = ers_pkg::MOT_IDLE;
                    end
                    else
                    begin
                        if (target_reg > car_reg)
                        begin
                            motion_next = ers_pkg::MOT_UP;
                        end
                        else if (target_reg < car_reg)
                        begin
                            motion_next = ers_pkg::MOT_DOWN;
                        end
                        car_next           = car_moved;
                        res_sup_next       = up_reg[car_idx];
                        res_sdn_next       = dn_reg[car_idx];
                        up_next[car_idx]   = 1'b0;
                        dn_next[car_idx]   = 1'b0;
                    end
                    res_valid_next  = 1'b1;
                    res_car_next    = car_next;
                    res_motion_next = motion_next;
                    res_target_next = target_reg;
                    res_status_next = ers_pkg::ST_OK;
                    res_pend_next   = (|up_next) || (|dn_next);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            up_reg         <= '0;
            dn_reg         <= '0;
            car_reg        <= 7'd1;
            motion_reg     <= ers_pkg::MOT_IDLE;
            scan_start_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            up_reg         <= up_next;
            dn_reg         <= dn_next;
            car_reg        <= car_next;
            motion_reg     <= motion_next;
            scan_start_reg <= scan_start_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        floor_reg      <= floor_next;
        going_up_reg   <= going_up_next;
        target_reg     <= target_next;
        res_car_reg    <= res_car_next;
        res_motion_reg <= res_motion_next;
        res_target_reg <= res_target_next;
        res_sup_reg    <= res_sup_next;
        res_sdn_reg    <= res_sdn_next;
        res_status_reg <= res_status_next;
        res_pend_reg   <= res_pend_next;
    end

    assign req.ready          = (state_reg == S_IDLE);
    assign res.valid          = res_valid_reg;
    assign res.car_position   = res_car_reg;
    assign res.motion         = res_motion_reg;
    assign res.target_floor   = res_target_reg;
    assign res.served_up      = res_sup_reg;
    assign res.served_down    = res_sdn_reg;
    assign res.request_status = res_status_reg;
    assign res.pending_any    = res_pend_reg;

endmodule

// ----- bench/elevator_request_scheduler_tb.sv -----
// self-checking testbench for the elevator request scheduler
module elevator_request_scheduler_tb;

    localparam int CAPACITY    = 64;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 115;
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_PHASE = 2;
    localparam int STALL_PHASE = 6;
    localparam logic [ers_pkg::ADDR_W-1:0] FLOOR_COUNT_ADDR = {ers_pkg::REG_FLOOR_COUNT, 2'b00};

    typedef struct packed {
        logic [ers_pkg::FLOOR_W-1:0] car_position;
        ers_pkg::motion_t            motion;
        logic [ers_pkg::FLOOR_W-1:0] target_floor;
        logic                        served_up;
        logic                        served_down;
        ers_pkg::status_t            request_status;
        logic                        pending_any;
    } car_report_t;

    typedef struct {
        logic                        mode;
        logic [ers_pkg::FLOOR_W-1:0] floor_no;
        logic                        going_up;
        bit                          fixed;
        car_report_t                 report;
    } hall_row_t;

    logic                        clk;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [ers_pkg::ADDR_W-1:0]  paddr;
    logic [ers_pkg::DATA_W-1:0]  pwdata;
    logic [ers_pkg::DATA_W-1:0]  prdata;
    logic                        pready;

    ers_request_if hall_req ();
    ers_result_if  car_res ();

    logic [63:0]                 up_calls;
    logic [63:0]                 down_calls;
    logic [ers_pkg::FLOOR_W-1:0] car_floor;
    ers_pkg::motion_t            car_motion;
    logic [ers_pkg::FLOOR_W-1:0] floor_count;

    car_report_t        expected_reports [$];
    int                 mismatches;
    bit                 quiet_phase;
    bit                 stall_phase;
    int                 cycles;

    hall_row_t directed_rows [0:20] = '{
        '{ers_pkg::MODE_TICK, 7'd0,   1'b0, 1'b1,
          '{7'd1, ers_pkg::MOT_IDLE, 7'd0, 1'b0, 1'b0, ers_pkg::ST_OK,       1'b0}},
        '{ers_pkg::MODE_ADD,  7'd0,   1'b1, 1'b1,
          '{7'd1, ers_pkg::MOT_IDLE, 7'd0, 1'b0, 1'b0, ers_pkg::ST_INVALID,  1'b0}},
        '{ers_pkg::MODE_ADD,  7'd127, 1'b0, 1'b1,
          '{7'd1, ers_pkg::MOT_IDLE, 7'd0, 1'b0, 1'b0, ers_pkg::ST_INVALID,  1'b0}},
        '{ers_pkg::MODE_ADD,  7'd65,  1'b1, 1'b1,
          '{7'd1, ers_pkg::MOT_IDLE, 7'd0, 1'b0, 1'b0, ers_pkg::ST_INVALID,  1'b0}},
        '{ers_pkg::MODE_ADD,  7'd1,   1'b0, 1'b1,
          '{7'd1, ers_pkg::MOT_IDLE, 7'd0, 1'b0, 1'b0, ers_pkg::ST_AT_FLOOR, 1'b0}},
        '{ers_pkg::MODE_ADD,  7'd64,  1'b1, 1'b1,
          '{7'd1, ers_pkg::MOT_IDLE, 7'd0, 1'b0, 1'b0, ers_pkg::ST_OK,       1'b1}},
        '{ers_pkg::MODE_ADD,  7'd64,  1'b1, 1'b1,
          '{7'd1, ers_pkg::MOT_IDLE, 7'd0, 1'b0, 1'b0, ers_pkg::ST_DUP,      1'b1}},
        '{ers_pkg::MODE_ADD,  7'd64,  1'b0, 1'b1,
          '{7'd1, ers_pkg::MOT_IDLE, 7'd0, 1'b0, 1'b0, ers_pkg::ST_OK,       1'b1}},
        '{ers_pkg::MODE_ADD,  7'd3,   1'b0, 1'b0, '0},
        '{ers_pkg::MODE_ADD,  7'd5,   1'b1, 1'b0, '0},
        '{ers_pkg::MODE_ADD,  7'd2,   1'b1, 1'b0, '0},
        '{ers_pkg::MODE_TICK, 7'd85,  1'b1, 1'b0, '0},
        '{ers_pkg::MODE_TICK, 7'd42,  1'b0, 1'b0, '0},
        '{ers_pkg::MODE_ADD,  7'd2,   1'b0, 1'b0, '0},
        '{ers_pkg::MODE_TICK, 7'd0,   1'b0, 1'b0, '0},
        '{ers_pkg::MODE_TICK, 7'd127, 1'b1, 1'b0, '0},
        '{ers_pkg::MODE_TICK, 7'd0,   1'b0, 1'b0, '0},
        '{ers_pkg::MODE_ADD,  7'd42,  1'b0, 1'b0, '0},
        '{ers_pkg::MODE_ADD,  7'd85,  1'b1, 1'b0, '0},
        '{ers_pkg::MODE_TICK, 7'd0,   1'b0, 1'b0, '0},
        '{ers_pkg::MODE_TICK, 7'd0,   1'b1, 1'b0, '0}
    };

    logic [ers_pkg::FLOOR_W-1:0] phase_counts [0:11] = '{
        7'd2, 7'd5, 7'd64, 7'd0, 7'd127, 7'd9, 7'd33, 7'd64, 7'd3, 7'd100, 7'd17, 7'd64
    };

    elevator_request_scheduler #(
        .FLOOR_CAPACITY(CAPACITY)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .req(hall_req),
        .res(car_res)
    );

    function automatic logic [ers_pkg::FLOOR_W-1:0] lowest_call_above(logic [63:0] map,
                                                                      int lim);
        int f;
        for (f = lim + 1; f <= CAPACITY; f++)
            if (f >= 1 && map[f-1])
                return ers_pkg::FLOOR_W'(f);
        return '0;
    endfunction

    function automatic logic [ers_pkg::FLOOR_W-1:0] highest_call_below(logic [63:0] map,
                                                                       int lim);
        int f;
        for (f = lim - 1; f >= 1; f--)
            if (f <= CAPACITY && map[f-1])
                return ers_pkg::FLOOR_W'(f);
        return '0;
    endfunction

    function automatic logic [ers_pkg::FLOOR_W-1:0] pick_target();
        logic [ers_pkg::FLOOR_W-1:0] hit;
        logic [ers_pkg::FLOOR_W-1:0] lo_up;
        logic [ers_pkg::FLOOR_W-1:0] hi_dn;
        int                          d_up;
        int                          d_dn;
        if (up_calls == '0 && down_calls == '0)
            return '0;
        if (car_motion == ers_pkg::MOT_UP)
        begin
            hit = lowest_call_above(up_calls, int'(car_floor));
            if (hit != '0)
                return hit;
            if (down_calls != '0)
                return highest_call_below(down_calls, CAPACITY + 1);
        end
        else if (car_motion == ers_pkg::MOT_DOWN)
        begin
            hit = highest_call_below(down_calls, int'(car_floor));
            if (hit != '0)
                return hit;
            if (up_calls != '0)
                return highest_call_below(up_calls, CAPACITY + 1);
        end
        lo_up = lowest_call_above(up_calls, 0);
        hi_dn = highest_call_below(down_calls, CAPACITY + 1);
        if (up_calls != '0 && down_calls != '0)
        begin
            d_up = int'(lo_up) - int'(car_floor);
            d_dn = int'(hi_dn) - int'(car_floor);
            if (d_up < 0)
                d_up = -d_up;
            if (d_dn < 0)
                d_dn = -d_dn;
            return (d_up <= d_dn) ? lo_up : hi_dn;
        end
        if (up_calls != '0)
            return lo_up;
        return hi_dn;
    endfunction

    function automatic car_report_t step_scheduler(logic mode,
                                                   logic [ers_pkg::FLOOR_W-1:0] floor_no,
                                                   logic going_up);
        car_report_t                 rep;
        int                          lim;
        logic [ers_pkg::FLOOR_W-1:0] target;
        rep = '0;
        target = '0;
        rep.request_status = ers_pkg::ST_OK;
        lim = (floor_count > CAPACITY) ? CAPACITY : int'(floor_count);
        if (mode == ers_pkg::MODE_ADD)
        begin
            if (floor_no < 1 || floor_no > lim)
                rep.request_status = ers_pkg::ST_INVALID;
            else if (floor_no == car_floor)
                rep.request_status = ers_pkg::ST_AT_FLOOR;
            else if (going_up)
            begin
                if (up_calls[floor_no-1])
                    rep.request_status = ers_pkg::ST_DUP;
                else
                    up_calls[floor_no-1] = 1'b1;
            end
            else
            begin
                if (down_calls[floor_no-1])
                    rep.request_status = ers_pkg::ST_DUP;
                else
                    down_calls[floor_no-1] = 1'b1;
            end
        end
        else
        begin
            target = pick_target();
            if (target == '0)
                car_motion = ers_pkg::MOT_IDLE;
            else
            begin
                if (target > car_floor)
                begin
                    car_motion = ers_pkg::MOT_UP;
                    car_floor++;
                end
                else if (target < car_floor)
                begin
                    car_motion = ers_pkg::MOT_DOWN;
                    car_floor--;
                end
                if (up_calls[car_floor-1])
                begin
                    up_calls[car_floor-1] = 1'b0;
                    rep.served_up = 1'b1;
                end
                if (down_calls[car_floor-1])
                begin
                    down_calls[car_floor-1] = 1'b0;
                    rep.served_down = 1'b1;
                end
            end
        end
        rep.car_position = car_floor;
        rep.motion = car_motion;
        rep.target_floor = target;
        rep.pending_any = |{up_calls, down_calls};
        return rep;
    endfunction

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    task automatic apb_access(input logic write, input logic [ers_pkg::DATA_W-1:0] data,
                              output logic [ers_pkg::DATA_W-1:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= FLOOR_COUNT_ADDR;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_floor_count(input logic [ers_pkg::FLOOR_W-1:0] value);
        logic [ers_pkg::DATA_W-1:0] rdata;
        apb_access(1'b1, {(ers_pkg::DATA_W-ers_pkg::FLOOR_W)'($urandom), value}, rdata);
        floor_count = value;
        apb_access(1'b0, '0, rdata);
        compare_field("floor_count readback", 32'(floor_count),
                      32'(rdata[ers_pkg::FLOOR_W-1:0]));
    endtask

    task automatic offer_request(input logic mode, input logic [ers_pkg::FLOOR_W-1:0] floor_no,
                                 input logic going_up, input bit fixed,
                                 input car_report_t fixed_report);
        car_report_t predicted;
        if (!quiet_phase && $urandom_range(99) < 21)
        begin
            hall_req.valid <= 1'b0;
            repeat ($urandom_range(4, 1))
                @(posedge clk);
        end
        hall_req.valid <= 1'b1;
        hall_req.mode <= mode;
        hall_req.request_floor <= floor_no;
        hall_req.going_up <= going_up;
        @(posedge clk);
        while (!hall_req.ready)
            @(posedge clk);
        predicted = step_scheduler(mode, floor_no, going_up);
        expected_reports.push_back(fixed ? fixed_report : predicted);
    endtask

    task automatic offer_random_request();
        int                          roll;
        int                          lim;
        logic [ers_pkg::FLOOR_W-1:0] floor_no;
        lim = (floor_count > CAPACITY) ? CAPACITY : int'(floor_count);
        roll = $urandom_range(99);
        if (roll >= 38 && roll < 88 && lim >= 1)
            floor_no = ers_pkg::FLOOR_W'($urandom_range(lim, 1));
        else
            floor_no = ers_pkg::FLOOR_W'($urandom_range(127));
        offer_request(roll < 38 ? ers_pkg::MODE_TICK : ers_pkg::MODE_ADD, floor_no,
                      1'($urandom_range(1)), 1'b0, '0);
    endtask

    task automatic wait_all_reported();
        while (expected_reports.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("elevator_request_scheduler regression: fail");
                $finish;
            end
        end
    end

    // result side: readiness, long hold-off and checking
    initial
    begin : result_side
        int          hold_left;
        bit          held;
        car_report_t want;
        hold_left = 0;
        held = 1'b0;
        car_res.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (car_res.valid && car_res.ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual car %0d status %0d",
                             $time, car_res.car_position, car_res.request_status);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    compare_field("car_position", 32'(want.car_position),
                                  32'(car_res.car_position));
                    compare_field("motion", 32'(want.motion), 32'(car_res.motion));
                    compare_field("target_floor", 32'(want.target_floor),
                                  32'(car_res.target_floor));
                    compare_field("served_up", 32'(want.served_up), 32'(car_res.served_up));
                    compare_field("served_down", 32'(want.served_down),
                                  32'(car_res.served_down));
                    compare_field("request_status", 32'(want.request_status),
                                  32'(car_res.request_status));
                    compare_field("pending_any", 32'(want.pending_any),
                                  32'(car_res.pending_any));
                end
            end
            if (stall_phase && !held)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                car_res.ready <= 1'b0;
            end
            else
                car_res.ready <= quiet_phase || ($urandom_range(99) >= 21);
        end
    end

    initial
    begin : stimulus
        int phase;
        int n;
        logic [ers_pkg::DATA_W-1:0] rdata;
        mismatches = 0;
        quiet_phase = 1'b0;
        stall_phase = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hall_req.valid = 1'b0;
        hall_req.mode = ers_pkg::MODE_ADD;
        hall_req.request_floor = '0;
        hall_req.going_up = 1'b0;
        up_calls = '0;
        down_calls = '0;
        car_floor = 7'd1;
        car_motion = ers_pkg::MOT_IDLE;
        floor_count = ers_pkg::FLOOR_COUNT_RESET;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apb_access(1'b0, '0, rdata);
        compare_field("floor_count after reset", 32'(ers_pkg::FLOOR_COUNT_RESET),
                      32'(rdata[ers_pkg::FLOOR_W-1:0]));

        foreach (directed_rows[i])
            offer_request(directed_rows[i].mode, directed_rows[i].floor_no,
                          directed_rows[i].going_up, directed_rows[i].fixed,
                          directed_rows[i].report);

        for (phase = 0; phase < 12; phase++)
        begin
            hall_req.valid <= 1'b0;
            wait_all_reported();
            set_floor_count(phase_counts[phase]);
            quiet_phase = (phase == QUIET_PHASE);
            stall_phase = (phase == STALL_PHASE);
            for (n = 0; n < PHASE_ITEMS; n++)
                offer_random_request();
        end
        hall_req.valid <= 1'b0;
        quiet_phase = 1'b0;

        wait_all_reported();
        repeat (CAPACITY + 16)
            @(posedge clk);
        if (mismatches == 0)
            $display("elevator_request_scheduler regression: pass");
        else
            $display("elevator_request_scheduler regression: fail");
        $finish;
    end
endmodule
